// File: hdl/imsu_pkg.sv
// imsu_pkg: shared types and constants for the metropolis spin update block
// no dependencies
`timescale 1ns / 1ps

package imsu_pkg;

    typedef enum logic [2:0]
    {
        REQ_FLIP   = 3'd0,
        REQ_SITE   = 3'd1,
        REQ_BOND   = 3'd2,
        REQ_BOTTOM = 3'd3,
        REQ_TOP    = 3'd4
    } req_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SITE,
        ST_SLOT,
        ST_NBR,
        ST_SPIN,
        ST_ACC,
        ST_DECIDE,
        ST_DONE
    } state_t;

    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_BOTH  = 2'd2;

    // one neighbor term, as fetched from the tables
    typedef struct packed
    {
        logic use_term;    // term takes part in the sum
        logic is_field;    // boundary field instead of bond
        logic bond_ok;     // bond or field column inside table
        logic slot_ok;     // neighbor slot inside table
    } term_ctl_t;

endpackage

// File: hdl/imsu_accum.sv
// imsu_accum: shared accumulator that adds one neighbor term a step and does the final compare
// depends on imsu_pkg
`timescale 1ns / 1ps

module imsu_accum
    import imsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        add_en,
    input  logic        term_val,
    input  logic        term_neg,
    output logic signed [4:0] energy,
    input  logic [31:0] draw,
    input  logic [31:0] th_two,
    input  logic [31:0] th_four,
    input  logic [31:0] th_six,
    input  logic [31:0] th_eight,
    output logic        accept
);

    logic signed [3:0] sum_reg;
    logic signed [3:0] sum_next;
    logic [31:0]       th_sel;

    always_comb
    begin
        sum_next = sum_reg;
        if (clear)
            sum_next = 4'sd0;
        else if (add_en && term_val)
            sum_next = term_neg ? sum_reg - 4'sd1 : sum_reg + 4'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= 4'sd0;
        else
            sum_reg <= sum_next;
    end

    assign energy = {sum_reg, 1'b0};

    always_comb
    begin
        case (sum_reg)
            4'sd1:   th_sel = th_two;
            4'sd2:   th_sel = th_four;
            4'sd3:   th_sel = th_six;
            default: th_sel = th_eight;
        endcase
    end

    assign accept = (sum_reg <= 4'sd0) || (draw < th_sel);

endmodule

// File: hdl/ising_metropolis_spin_update_top.sv
// ising_metropolis_spin_update_top: metropolis single-spin update with table loads and apb config
// depends on imsu_pkg and imsu_accum
`timescale 1ns / 1ps

// A flip word reads its site, then visits all 4 neighbor terms in turn (slot, neighbor, spin,
// accumulate), then decides and raises done; all 4 terms are always visited. The time is set
// by the chain of registered table reads (site, slot, spin) and the single shared accumulator
// that adds one term per pass. A load word writes its table entry if in range and raises done.
// busy is high while a word is in work and drops the cycle after done, so a new word is taken
// only once the last one is through; done pulses one cycle with the result, which cannot be
// held off. Tables are undefined until loaded; the spin store resets to all up by a clearing
// pass over all LATTICE_SIDE*LATTICE_SIDE spins after reset, during which busy stays high.
module ising_metropolis_spin_update_top
    import imsu_pkg::*;
#(
    parameter int LATTICE_SIDE = 41
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [10:0] spin_index,
    input  logic [5:0]  row,
    input  logic [5:0]  column,
    input  logic [1:0]  side,
    input  logic        sign_negative,
    input  logic [31:0] random_draw,
    output logic        done,
    output logic        accepted,
    output logic signed [4:0] energy_change,
    output logic signed [2:0] magnetization_change,
    output logic        spin_after
);

    localparam int HALF_COLS  = (LATTICE_SIDE + 1) / 2;
    localparam int SITE_ROWS  = LATTICE_SIDE - 1;
    localparam int NUM_SPINS  = LATTICE_SIDE * LATTICE_SIDE;
    localparam int SLOT_DEPTH = SITE_ROWS * HALF_COLS * 2;
    localparam int BOND_ROWS  = LATTICE_SIDE - 2;
    localparam int BOND_DEPTH = BOND_ROWS * LATTICE_SIDE;
    localparam int SW = $clog2(NUM_SPINS);
    localparam int LW = $clog2(SLOT_DEPTH);
    localparam int BW = $clog2(BOND_DEPTH);
    localparam int FW = $clog2(LATTICE_SIDE);

    // config registers
    logic [31:0] th_reg [4];
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                th_reg[i] <= '0;
        end
        else if (cfg_wr && (paddr[1:0] == 2'd0))
        begin
            th_reg[paddr[3:2]] <= pwdata;
        end
    end

    assign prdata = (paddr[1:0] == 2'd0) ? th_reg[paddr[3:2]] : '0;

    // memories
    logic [12:0]  site_mem [NUM_SPINS];
    logic [SW-1:0] slot_mem [SLOT_DEPTH];
    logic         bond_mem [BOND_DEPTH];
    logic         bot_mem  [LATTICE_SIDE];
    logic         top_mem  [LATTICE_SIDE];
    logic         spin_mem [NUM_SPINS];

    // captured input word
    req_t         req_reg;
    logic [10:0]  id_reg;
    logic [5:0]   row_reg;
    logic [5:0]   col_reg;
    logic [1:0]   side_reg;
    logic         neg_reg;
    logic [31:0]  draw_reg;

    state_t       state_reg, state_next;
    logic [SW-1:0] clr_reg;
    logic         clearing_reg;
    logic [1:0]   term_reg, term_next;
    logic [12:0]  site_q;
    logic         self_q;
    logic [SW-1:0] nspin_q;
    logic         sign_q;
    logic         nval_q;
    term_ctl_t    ctl_reg;
    logic         acc_clear, acc_add, acc_accept;
    logic signed [4:0] acc_energy;
    logic         id_ok;

    assign id_ok = 32'(id_reg) < NUM_SPINS;
    assign busy  = (state_reg != ST_IDLE) || clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
            term_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_SPINS - 1)
                    clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg  <= req_t'(req_type);
            id_reg   <= spin_index;
            row_reg  <= row;
            col_reg  <= column;
            side_reg <= side;
            neg_reg  <= sign_negative;
            draw_reg <= random_draw;
        end
    end

    // current term geometry
    logic [5:0] si;
    logic [4:0] sj;
    logic [1:0] sk;
    logic       bottom_side, odd_row, right_term;
    logic signed [7:0] brow, bcol, nrow, ncol;
    logic       nhalf;
    logic       use_term, is_field;
    term_ctl_t  ctl_next;

    assign si = site_q[12:7];
    assign sj = site_q[6:2];
    assign sk = site_q[1:0];

    always_comb
    begin
        bottom_side = ~term_reg[1];
        right_term  = term_reg[0];
        odd_row     = si[0];
        use_term    = right_term ? (sk == SIDE_RIGHT || sk == SIDE_BOTH)
                                 : (sk == SIDE_LEFT || sk == SIDE_BOTH);
        brow  = bottom_side ? $signed({2'b0, si}) - 8'sd1 : $signed({2'b0, si});
        nrow  = bottom_side ? $signed({2'b0, si}) - 8'sd1 : $signed({2'b0, si}) + 8'sd1;
        bcol  = $signed({2'b0, sj, 1'b0}) + $signed({7'b0, odd_row}) + $signed({7'b0, right_term})
                - 8'sd1;
        ncol  = $signed({3'b0, sj}) + $signed({7'b0, odd_row}) + $signed({7'b0, right_term})
                - 8'sd1;
        nhalf = ~right_term;
        is_field = bottom_side ? (si == 6'd0) : (32'(si) >= LATTICE_SIDE - 2);
        if (is_field)
            bcol = $signed({2'b0, sj, 1'b0}) + $signed({7'b0, right_term})
                   - (bottom_side ? 8'sd1 : 8'sd0);
        ctl_next.use_term = use_term;
        ctl_next.is_field = is_field;
        ctl_next.bond_ok  = (bcol >= 0) && (32'(bcol) < LATTICE_SIDE)
                            && (is_field || (brow >= 0 && 32'(brow) < BOND_ROWS));
        ctl_next.slot_ok  = (nrow >= 0) && (32'(nrow) < SITE_ROWS)
                            && (ncol >= 0) && (32'(ncol) < HALF_COLS);
    end

    logic [LW-1:0] slot_addr;
    logic [BW-1:0] bond_addr;
    logic [FW-1:0] fld_addr;
    assign slot_addr = LW'((32'(nrow) * HALF_COLS + 32'(ncol)) * 2 + 32'(nhalf));
    assign bond_addr = BW'(32'(brow) * LATTICE_SIDE + 32'(bcol));
    assign fld_addr  = FW'(bcol);

    // memory writes and reads
    logic spin_wr;
    logic flip_bit;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SITE && req_reg == REQ_SITE && id_ok
            && 32'(row_reg) < SITE_ROWS && 32'(col_reg) < HALF_COLS && side_reg <= SIDE_BOTH)
        begin
            site_mem[id_reg[SW-1:0]] <= {row_reg, col_reg[4:0], side_reg};
            if (side_reg != SIDE_RIGHT)
                slot_mem[LW'((32'(row_reg) * HALF_COLS + 32'(col_reg)) * 2)] <= id_reg[SW-1:0];
            if (side_reg != SIDE_LEFT)
                slot_mem[LW'((32'(row_reg) * HALF_COLS + 32'(col_reg)) * 2 + 1)]
                    <= id_reg[SW-1:0];
        end
        if (state_reg == ST_SITE && req_reg == REQ_BOND
            && 32'(row_reg) < BOND_ROWS && 32'(col_reg) < LATTICE_SIDE)
            bond_mem[BW'(32'(row_reg) * LATTICE_SIDE + 32'(col_reg))] <= neg_reg;
        if (state_reg == ST_SITE && req_reg == REQ_BOTTOM && 32'(col_reg) < LATTICE_SIDE)
            bot_mem[FW'(col_reg)] <= neg_reg;
        if (state_reg == ST_SITE && req_reg == REQ_TOP && 32'(col_reg) < LATTICE_SIDE)
            top_mem[FW'(col_reg)] <= neg_reg;

        site_q <= site_mem[id_reg[SW-1:0]];
        if (state_reg == ST_SLOT)
        begin
            ctl_reg <= ctl_next;
            nspin_q <= slot_mem[slot_addr];
            if (is_field)
                sign_q <= bottom_side ? bot_mem[fld_addr] : top_mem[fld_addr];
            else
                sign_q <= bond_mem[bond_addr];
        end
        if (state_reg == ST_NBR)
            nval_q <= (32'(nspin_q) < NUM_SPINS) ? spin_mem[nspin_q] : 1'b0;
        if (state_reg == ST_SITE)
            self_q <= spin_mem[id_reg[SW-1:0]];
        if (clearing_reg)
            spin_mem[clr_reg] <= 1'b0;
        else if (spin_wr)
            spin_mem[id_reg[SW-1:0]] <= flip_bit;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                term_next = '0;
                if (start && !busy)
                    state_next = ST_SITE;
            end
            ST_SITE:
                state_next = (req_reg == REQ_FLIP && id_ok) ? ST_SLOT : ST_DONE;
            ST_SLOT:  state_next = ST_NBR;
            ST_NBR:   state_next = ST_SPIN;
            ST_SPIN:  state_next = ST_ACC;
            ST_ACC:
            begin
                term_next  = term_reg + 2'd1;
                state_next = (term_reg == 2'd3) ? ST_DECIDE : ST_SLOT;
            end
            ST_DECIDE: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    logic term_val, term_neg;
    always_comb
    begin
        acc_clear = 1'b0;
        acc_add   = 1'b0;
        spin_wr   = 1'b0;
        case (state_reg)
            ST_SITE:   acc_clear = 1'b1;
            ST_ACC:    acc_add   = 1'b1;
            ST_DECIDE: spin_wr   = acc_accept;
            default:   acc_add   = 1'b0;
        endcase
    end

    assign term_val = ctl_reg.use_term && ctl_reg.bond_ok && (ctl_reg.is_field || ctl_reg.slot_ok);
    assign term_neg = sign_q ^ self_q ^ (ctl_reg.is_field ? 1'b0 : nval_q);
    assign flip_bit = ~self_q;

    imsu_accum u_accum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (acc_clear),
        .add_en   (acc_add),
        .term_val (term_val),
        .term_neg (term_neg),
        .energy   (acc_energy),
        .draw     (draw_reg),
        .th_two   (th_reg[0]),
        .th_four  (th_reg[1]),
        .th_six   (th_reg[2]),
        .th_eight (th_reg[3]),
        .accept   (acc_accept)
    );

    // result register
    logic is_flip_res;
    logic acc_hold;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_flip_res <= 1'b0;
            acc_hold    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_SITE)
                is_flip_res <= (req_reg == REQ_FLIP) && id_ok;
            if (state_reg == ST_DECIDE)
                acc_hold <= acc_accept;
        end
    end

    assign done                 = (state_reg == ST_DONE);
    assign accepted             = is_flip_res & acc_hold;
    assign energy_change        = is_flip_res ? acc_energy : 5'sd0;
    assign magnetization_change = is_flip_res ? (self_q ? 3'sd2 : -3'sd2) : 3'sd0;
    assign spin_after           = is_flip_res & (self_q ^ acc_hold);

endmodule
